// ===== design/gtp_pkg.sv =====
// Shared widths, constants and types of the grid tile placement block.
package gtp_pkg;

   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 4;
   localparam int DIM_FIELD_W = 13;
   localparam int GRID_W      = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   localparam int MAX_TILES_DEFAULT     = 16;
   localparam int MAX_DIMENSION_DEFAULT = 4096;

   // Q.16 aspect target 1.778 and empty-cell penalty 0.1
   localparam int          ASPECT_FRAC_W     = 16;
   localparam int unsigned ASPECT_TARGET_Q16 = 116523;
   localparam int unsigned EMPTY_PENALTY_Q16 = 6554;

   localparam logic [DIM_FIELD_W-1:0] FIELD13_MAX         = 13'h1FFF;
   localparam logic [DIM_FIELD_W-1:0] CANVAS_WIDTH_RESET  = 13'd1280;
   localparam logic [DIM_FIELD_W-1:0] CANVAS_HEIGHT_RESET = 13'd720;
   localparam logic                   KEEP_ASPECT_RESET   = 1'b1;

   typedef enum logic [1:0] {
      REG_CANVAS_WIDTH  = 2'd0,
      REG_CANVAS_HEIGHT = 2'd1,
      REG_KEEP_ASPECT   = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== design/gtp_channels.sv =====
// Request and response channel interfaces of the grid tile placement block.
interface gtp_req_if import gtp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_W-1:0]     tile_count;
   logic [INDEX_W-1:0]     tile_index;
   logic [DIM_FIELD_W-1:0] source_width;
   logic [DIM_FIELD_W-1:0] source_height;

   modport source (output valid, tile_count, tile_index, source_width, source_height,
                   input ready);
   modport sink (input valid, tile_count, tile_index, source_width, source_height,
                 output ready);
endinterface

interface gtp_rsp_if import gtp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [GRID_W-1:0]      grid_columns;
   logic [GRID_W-1:0]      grid_rows;
   logic [DIM_FIELD_W-1:0] dest_x;
   logic [DIM_FIELD_W-1:0] dest_y;
   logic [DIM_FIELD_W-1:0] fit_width;
   logic [DIM_FIELD_W-1:0] fit_height;
   logic                   luma_fits;
   logic                   chroma_fits;

   modport source (output valid, grid_columns, grid_rows, dest_x, dest_y, fit_width,
                   fit_height, luma_fits, chroma_fits, input ready);
   modport sink (input valid, grid_columns, grid_rows, dest_x, dest_y, fit_width,
                 fit_height, luma_fits, chroma_fits, output ready);
endinterface

// ===== design/gtp_div.sv =====
// Shared restoring divider, one quotient bit per cycle, variable bit count.
module gtp_div import gtp_pkg::*; #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 26,
   parameter int BITS_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BITS_W-1:0] bits,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [NUM_W-1:0]  quo,
   output logic [DEN_W-1:0]  rem,
   output div_stat_type      stat
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BITS_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  shift_ff, shift_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W:0]    partial;
   logic [DEN_W:0]    trial;
   logic              take;

   assign partial = {rem_ff, shift_ff[NUM_W-1]};
   assign trial   = partial - {1'b0, den};
   assign take    = partial >= {1'b0, den};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         // left-align the numerator so only its low bits are iterated
         shift_in = num << (BITS_W'(NUM_W) - bits);
         rem_in   = '0;
         cnt_in   = bits;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[NUM_W-2:0], take};
         rem_in   = take ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
         cnt_in   = cnt_ff - BITS_W'(1);
         if (cnt_ff == BITS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign quo       = shift_ff;
   assign rem       = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== design/grid_tile_placement.sv =====
// Top level of the grid tile placement block: sequencer, shared multiplier, CSRs.
//
// Places one tile of a video mosaic on the output canvas. The req channel
// carries tile count, tile index and source size; the rsp channel returns the
// chosen grid, the placed rectangle and two canvas-fit flags. Canvas size and
// the letterbox/stretch mode come from three CSRs on the APB-style csr_ port
// (byte addresses 0, 4, 8); write them only while the block is idle.
//
// One transfer is worked at a time: req.ready is high only while the
// sequencer is idle. All math runs through one registered multiplier and one
// restoring divider (a quotient bit per cycle) that sets the latency. Stretch
// mode skips the letterbox fit steps; five or more tiles add a column search
// with one count divide plus one aspect divide (34-bit with default
// parameters) per candidate column.
//
// Reset (synchronous) returns the CSRs to 1280 x 720 letterbox and empties the
// result register. A finished result waits in the rsp register while the
// receiver stalls; the next item is accepted meanwhile, and its result waits
// at the end of its sequence until the register is free.
module grid_tile_placement import gtp_pkg::*; #(
   parameter int MAX_TILES     = MAX_TILES_DEFAULT,
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   gtp_req_if.sink               req,
   gtp_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W  = $clog2(MAX_TILES + 1);
   localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
   localparam int PROD_W = 2 * DIM_W;
   localparam int NUM_W  = DIM_W + CNT_W + ASPECT_FRAC_W;
   localparam int DEN_W  = PROD_W;
   localparam int BITS_W = $clog2(NUM_W + 1);
   localparam int POS_W  = PROD_W + 1;
   localparam int SC_W   = NUM_W + 1;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_GRID     = 20'h00002,
      ST_ROW_DIV  = 20'h00004,
      ST_MUL_CR   = 20'h00008,
      ST_MUL_WR   = 20'h00010,
      ST_MUL_HC   = 20'h00020,
      ST_ASP_DIV  = 20'h00040,
      ST_SCORE    = 20'h00080,
      ST_CW_DIV   = 20'h00100,
      ST_CH_DIV   = 20'h00200,
      ST_MUL_SWCH = 20'h00400,
      ST_MUL_CWSH = 20'h00800,
      ST_CMP      = 20'h01000,
      ST_FIT_DIV  = 20'h02000,
      ST_OFFSET   = 20'h04000,
      ST_POS_DIV  = 20'h08000,
      ST_MUL_DX   = 20'h10000,
      ST_MUL_DY   = 20'h20000,
      ST_SUM_DY   = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_FIELD_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v < DIM_FIELD_W'(2)) begin
         r = DIM_W'(2);
      end else if (32'(v) > MAX_DIMENSION) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // control state
   state_type              state_ff, state_in;
   logic                   div_run_ff, div_run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIM_FIELD_W-1:0] canvas_width_ff, canvas_width_in;
   logic [DIM_FIELD_W-1:0] canvas_height_ff, canvas_height_in;
   logic                   keep_aspect_ff, keep_aspect_in;

   // working registers
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [DIM_W-1:0]       sw_ff, sw_in;
   logic [DIM_W-1:0]       sh_ff, sh_in;
   logic [CNT_W-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]       r_ff, r_in;
   logic [CNT_W-1:0]       cols_ff, cols_in;
   logic [CNT_W-1:0]       rows_ff, rows_in;
   logic [CNT_W-1:0]       empty_ff, empty_in;
   logic [SC_W-1:0]        best_ff, best_in;
   logic [NUM_W-1:0]       diff_ff, diff_in;
   logic [PROD_W-1:0]      tmp_ff, tmp_in;
   logic [PROD_W-1:0]      mul_ff, mul_in;
   logic [DIM_W-1:0]       cw_ff, cw_in;
   logic [DIM_W-1:0]       ch_ff, ch_in;
   logic [DIM_W-1:0]       fw_ff, fw_in;
   logic [DIM_W-1:0]       fh_ff, fh_in;
   logic [DIM_W-1:0]       ox_ff, ox_in;
   logic [DIM_W-1:0]       oy_ff, oy_in;
   logic                   wider_ff, wider_in;
   logic [INDEX_W-1:0]     pos_row_ff, pos_row_in;
   logic [INDEX_W-1:0]     pos_col_ff, pos_col_in;
   logic [POS_W-1:0]       dx_ff, dx_in;
   logic [POS_W-1:0]       dy_ff, dy_in;

   // result register
   logic [GRID_W-1:0]      out_cols_ff, out_cols_in;
   logic [GRID_W-1:0]      out_rows_ff, out_rows_in;
   logic [DIM_FIELD_W-1:0] out_dx_ff, out_dx_in;
   logic [DIM_FIELD_W-1:0] out_dy_ff, out_dy_in;
   logic [DIM_FIELD_W-1:0] out_fw_ff, out_fw_in;
   logic [DIM_FIELD_W-1:0] out_fh_ff, out_fh_in;
   logic                   out_luma_ff, out_luma_in;
   logic                   out_chroma_ff, out_chroma_in;

   // shared units
   logic                   mul_en;
   logic [DIM_W-1:0]       mul_a, mul_b;
   logic                   div_start;
   logic [BITS_W-1:0]      div_bits;
   logic [NUM_W-1:0]       div_num;
   logic [DEN_W-1:0]       div_den;
   logic [NUM_W-1:0]       div_quo;
   logic [DEN_W-1:0]       div_rem;
   div_stat_type           div_stat;

   // combinational helpers
   logic [DIM_W-1:0]       w, h;
   logic                   wide;
   logic [CNT_W:0]         row_num;
   logic [NUM_W-1:0]       target;
   logic [SC_W-1:0]        score;
   logic [DIM_W-1:0]       slack_half;
   logic [POS_W:0]         luma_x, luma_y, chroma_x, chroma_y;
   logic                   csr_write;
   csr_reg_type            csr_sel;

   assign w          = clamp_dim(canvas_width_ff);
   assign h          = clamp_dim(canvas_height_ff);
   assign wide       = {1'b0, w, 1'b0} >= ({2'b0, h} + {1'b0, h, 1'b0});
   assign row_num    = {1'b0, cnt_ff} + {1'b0, col_ff} - (CNT_W + 1)'(1);
   assign target     = NUM_W'(ASPECT_TARGET_Q16);
   assign score      = SC_W'(diff_ff) + SC_W'(EMPTY_PENALTY_Q16) * SC_W'(empty_ff);
   assign slack_half = wider_ff ? ((ch_ff - fh_ff) >> 1) : ((cw_ff - fw_ff) >> 1);
   assign luma_x     = (POS_W + 1)'(dx_ff) + (POS_W + 1)'(fw_ff);
   assign luma_y     = (POS_W + 1)'(dy_ff) + (POS_W + 1)'(fh_ff);
   assign chroma_x   = (POS_W + 1)'(dx_ff >> 1) + (POS_W + 1)'(fw_ff >> 1);
   assign chroma_y   = (POS_W + 1)'(dy_ff >> 1) + (POS_W + 1)'(fh_ff >> 1);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[3:2]);

   assign mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   gtp_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .BITS_W (BITS_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .bits  (div_bits),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .rem   (div_rem),
      .stat  (div_stat)
   );

   // Route multiplier operands by step.
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         ST_MUL_CR: begin
            mul_a = DIM_W'(col_ff);
            mul_b = DIM_W'(r_ff);
         end
         ST_MUL_WR: begin
            mul_a = w;
            mul_b = DIM_W'(r_ff);
         end
         ST_MUL_HC: begin
            mul_a = h;
            mul_b = DIM_W'(col_ff);
         end
         ST_MUL_SWCH: begin
            mul_a = sw_ff;
            mul_b = ch_ff;
         end
         ST_MUL_CWSH: begin
            mul_a = cw_ff;
            mul_b = sh_ff;
         end
         ST_MUL_DX: begin
            mul_a = DIM_W'(pos_col_ff);
            mul_b = cw_ff;
         end
         ST_MUL_DY: begin
            mul_a = DIM_W'(pos_row_ff);
            mul_b = ch_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Route divider operands by step.
   always_comb begin
      div_num  = '0;
      div_den  = DEN_W'(1);
      div_bits = BITS_W'(1);
      unique case (state_ff)
         ST_ROW_DIV: begin
            div_num  = NUM_W'(row_num);
            div_den  = DEN_W'(col_ff);
            div_bits = BITS_W'(CNT_W + 1);
         end
         ST_ASP_DIV: begin
            div_num  = NUM_W'(tmp_ff) << ASPECT_FRAC_W;
            div_den  = DEN_W'(mul_ff);
            div_bits = BITS_W'(NUM_W);
         end
         ST_CW_DIV: begin
            div_num  = NUM_W'(w);
            div_den  = DEN_W'(cols_ff);
            div_bits = BITS_W'(DIM_W);
         end
         ST_CH_DIV: begin
            div_num  = NUM_W'(h);
            div_den  = DEN_W'(rows_ff);
            div_bits = BITS_W'(DIM_W);
         end
         ST_FIT_DIV: begin
            div_num  = wider_ff ? NUM_W'(mul_ff) : NUM_W'(tmp_ff);
            div_den  = wider_ff ? DEN_W'(sw_ff) : DEN_W'(sh_ff);
            div_bits = BITS_W'(PROD_W);
         end
         ST_POS_DIV: begin
            div_num  = NUM_W'(idx_ff);
            div_den  = DEN_W'(cols_ff);
            div_bits = BITS_W'(INDEX_W);
         end
         default: begin
            div_bits = BITS_W'(1);
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      div_run_in    = div_run_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      sw_in         = sw_ff;
      sh_in         = sh_ff;
      col_in        = col_ff;
      r_in          = r_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      empty_in      = empty_ff;
      best_in       = best_ff;
      diff_in       = diff_ff;
      tmp_in        = tmp_ff;
      cw_in         = cw_ff;
      ch_in         = ch_ff;
      fw_in         = fw_ff;
      fh_in         = fh_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      wider_in      = wider_ff;
      pos_row_in    = pos_row_ff;
      pos_col_in    = pos_col_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      out_cols_in   = out_cols_ff;
      out_rows_in   = out_rows_ff;
      out_dx_in     = out_dx_ff;
      out_dy_in     = out_dy_ff;
      out_fw_in     = out_fw_ff;
      out_fh_in     = out_fh_ff;
      out_luma_in   = out_luma_ff;
      out_chroma_in = out_chroma_ff;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // each divide step: start the divider once, then wait for its done pulse
      if (!div_run_ff && (state_ff == ST_ROW_DIV || state_ff == ST_ASP_DIV ||
                          state_ff == ST_CW_DIV || state_ff == ST_CH_DIV ||
                          state_ff == ST_FIT_DIV || state_ff == ST_POS_DIV)) begin
         div_start  = 1'b1;
         div_run_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cnt_in   = (32'(req.tile_count) > MAX_TILES) ? CNT_W'(MAX_TILES)
                                                            : CNT_W'(req.tile_count);
               idx_in   = req.tile_index;
               sw_in    = clamp_dim(req.source_width);
               sh_in    = clamp_dim(req.source_height);
               state_in = ST_GRID;
            end
         end
         ST_GRID: begin
            // fixed layouts for up to four tiles, else search column counts
            state_in = ST_CW_DIV;
            priority if (cnt_ff <= CNT_W'(1)) begin
               cols_in = CNT_W'(1);
               rows_in = CNT_W'(1);
            end else if (cnt_ff == CNT_W'(2)) begin
               cols_in = wide ? CNT_W'(2) : CNT_W'(1);
               rows_in = wide ? CNT_W'(1) : CNT_W'(2);
            end else if (cnt_ff == CNT_W'(3)) begin
               cols_in = wide ? CNT_W'(3) : CNT_W'(2);
               rows_in = wide ? CNT_W'(1) : CNT_W'(2);
            end else if (cnt_ff == CNT_W'(4)) begin
               cols_in = CNT_W'(2);
               rows_in = CNT_W'(2);
            end else begin
               col_in   = CNT_W'(1);
               best_in  = '1;
               state_in = ST_ROW_DIV;
            end
         end
         ST_ROW_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               r_in       = CNT_W'(div_quo);
               state_in   = ST_MUL_CR;
            end
         end
         ST_MUL_CR: begin
            state_in = ST_MUL_WR;
         end
         ST_MUL_WR: begin
            empty_in = CNT_W'(mul_ff) - cnt_ff;
            state_in = ST_MUL_HC;
         end
         ST_MUL_HC: begin
            tmp_in   = mul_ff;
            state_in = ST_ASP_DIV;
         end
         ST_ASP_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               diff_in    = (div_quo >= target) ? div_quo - target : target - div_quo;
               state_in   = ST_SCORE;
            end
         end
         ST_SCORE: begin
            // strict compare keeps the first minimum
            if (score < best_ff) begin
               best_in = score;
               cols_in = col_ff;
               rows_in = r_ff;
            end
            if (col_ff == cnt_ff) begin
               state_in = ST_CW_DIV;
            end else begin
               col_in   = col_ff + CNT_W'(1);
               state_in = ST_ROW_DIV;
            end
         end
         ST_CW_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               cw_in      = DIM_W'(div_quo);
               state_in   = ST_CH_DIV;
            end
         end
         ST_CH_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               ch_in      = DIM_W'(div_quo);
               if (keep_aspect_ff) begin
                  state_in = ST_MUL_SWCH;
               end else begin
                  // stretch: cell size as is, no offsets
                  fw_in    = cw_ff;
                  fh_in    = DIM_W'(div_quo);
                  ox_in    = '0;
                  oy_in    = '0;
                  state_in = ST_POS_DIV;
               end
            end
         end
         ST_MUL_SWCH: begin
            state_in = ST_MUL_CWSH;
         end
         ST_MUL_CWSH: begin
            tmp_in   = mul_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            wider_in = tmp_ff > mul_ff;
            state_in = ST_FIT_DIV;
         end
         ST_FIT_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               if (wider_ff) begin
                  fw_in = cw_ff;
                  fh_in = DIM_W'(div_quo);
               end else begin
                  fw_in = DIM_W'(div_quo);
                  fh_in = ch_ff;
               end
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            // offset from the odd sizes, then even everything down
            if (wider_ff) begin
               ox_in = '0;
               oy_in = {slack_half[DIM_W-1:1], 1'b0};
            end else begin
               ox_in = {slack_half[DIM_W-1:1], 1'b0};
               oy_in = '0;
            end
            fw_in    = {fw_ff[DIM_W-1:1], 1'b0};
            fh_in    = {fh_ff[DIM_W-1:1], 1'b0};
            state_in = ST_POS_DIV;
         end
         ST_POS_DIV: begin
            if (div_stat.done) begin
               div_run_in = 1'b0;
               pos_row_in = INDEX_W'(div_quo);
               pos_col_in = INDEX_W'(div_rem);
               state_in   = ST_MUL_DX;
            end
         end
         ST_MUL_DX: begin
            state_in = ST_MUL_DY;
         end
         ST_MUL_DY: begin
            dx_in    = POS_W'(mul_ff) + POS_W'(ox_ff);
            state_in = ST_SUM_DY;
         end
         ST_SUM_DY: begin
            dy_in    = POS_W'(mul_ff) + POS_W'(oy_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp.ready) begin
               out_cols_in   = GRID_W'(cols_ff);
               out_rows_in   = GRID_W'(rows_ff);
               out_dx_in     = (dx_ff > POS_W'(FIELD13_MAX)) ? FIELD13_MAX
                                                             : DIM_FIELD_W'(dx_ff);
               out_dy_in     = (dy_ff > POS_W'(FIELD13_MAX)) ? FIELD13_MAX
                                                             : DIM_FIELD_W'(dy_ff);
               out_fw_in     = DIM_FIELD_W'(fw_ff);
               out_fh_in     = DIM_FIELD_W'(fh_ff);
               out_luma_in   = (luma_x <= (POS_W + 1)'(w)) && (luma_y <= (POS_W + 1)'(h));
               out_chroma_in = (chroma_x <= (POS_W + 1)'(w >> 1)) &&
                               (chroma_y <= (POS_W + 1)'(h >> 1));
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      keep_aspect_in   = keep_aspect_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_CANVAS_WIDTH:  canvas_width_in  = csr_pwdata[DIM_FIELD_W-1:0];
            REG_CANVAS_HEIGHT: canvas_height_in = csr_pwdata[DIM_FIELD_W-1:0];
            REG_KEEP_ASPECT:   keep_aspect_in   = csr_pwdata[0];
            default: begin
               keep_aspect_in = keep_aspect_ff;
            end
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      unique case (csr_sel)
         REG_CANVAS_WIDTH:  csr_prdata = CSR_DATA_W'(canvas_width_ff);
         REG_CANVAS_HEIGHT: csr_prdata = CSR_DATA_W'(canvas_height_ff);
         REG_KEEP_ASPECT:   csr_prdata = CSR_DATA_W'(keep_aspect_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         div_run_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         canvas_width_ff  <= CANVAS_WIDTH_RESET;
         canvas_height_ff <= CANVAS_HEIGHT_RESET;
         keep_aspect_ff   <= KEEP_ASPECT_RESET;
      end else begin
         state_ff         <= state_in;
         div_run_ff       <= div_run_in;
         rsp_valid_ff     <= rsp_valid_in;
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
         keep_aspect_ff   <= keep_aspect_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_ff <= mul_in;
      end
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      sw_ff         <= sw_in;
      sh_ff         <= sh_in;
      col_ff        <= col_in;
      r_ff          <= r_in;
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      empty_ff      <= empty_in;
      best_ff       <= best_in;
      diff_ff       <= diff_in;
      tmp_ff        <= tmp_in;
      cw_ff         <= cw_in;
      ch_ff         <= ch_in;
      fw_ff         <= fw_in;
      fh_ff         <= fh_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      wider_ff      <= wider_in;
      pos_row_ff    <= pos_row_in;
      pos_col_ff    <= pos_col_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      out_cols_ff   <= out_cols_in;
      out_rows_ff   <= out_rows_in;
      out_dx_ff     <= out_dx_in;
      out_dy_ff     <= out_dy_in;
      out_fw_ff     <= out_fw_in;
      out_fh_ff     <= out_fh_in;
      out_luma_ff   <= out_luma_in;
      out_chroma_ff <= out_chroma_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.grid_columns = out_cols_ff;
   assign rsp.grid_rows    = out_rows_ff;
   assign rsp.dest_x       = out_dx_ff;
   assign rsp.dest_y       = out_dy_ff;
   assign rsp.fit_width    = out_fw_ff;
   assign rsp.fit_height   = out_fh_ff;
   assign rsp.luma_fits    = out_luma_ff;
   assign rsp.chroma_fits  = out_chroma_ff;

   a_accept_starts_grid: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_GRID))
      else $error("accepted transfer did not start grid selection");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_div_done_in_step: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_ROW_DIV || state_ff == ST_ASP_DIV ||
                         state_ff == ST_CW_DIV || state_ff == ST_CH_DIV ||
                         state_ff == ST_FIT_DIV || state_ff == ST_POS_DIV))
      else $error("divider finished outside a divide step");

   a_search_column_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCORE) |-> (col_ff != '0) && (col_ff <= cnt_ff))
      else $error("candidate column count out of range");

   a_fit_within_cell: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (fw_ff <= cw_ff) && (fh_ff <= ch_ff))
      else $error("placed picture larger than its cell");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the grid tile placement block.
module tb;
   import gtp_pkg::*;

   // One tile request as it crosses the req channel
   typedef struct {
      logic [COUNT_W-1:0]     tile_count;
      logic [INDEX_W-1:0]     tile_index;
      logic [DIM_FIELD_W-1:0] source_width;
      logic [DIM_FIELD_W-1:0] source_height;
   } tile_req_type;

   // One placement as it crosses the rsp channel
   typedef struct {
      logic [GRID_W-1:0]      grid_columns;
      logic [GRID_W-1:0]      grid_rows;
      logic [DIM_FIELD_W-1:0] dest_x;
      logic [DIM_FIELD_W-1:0] dest_y;
      logic [DIM_FIELD_W-1:0] fit_width;
      logic [DIM_FIELD_W-1:0] fit_height;
      logic                   luma_fits;
      logic                   chroma_fits;
   } placement_type;

   localparam int RANDOM_PHASES    = 12;
   localparam int TILES_PER_PHASE  = 125;
   localparam int LONG_HOLD_CYCLES = 3000;
   // Sized to outlast the worst case, a 16-tile search.
   localparam int DRAIN_CYCLES     = 2000;

   logic clock;
   logic reset;

   gtp_req_if req_ch ();
   gtp_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_tile_placement dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the CSRs, updated once all three writes complete
   logic [DIM_FIELD_W-1:0] canvas_w_cfg;
   logic [DIM_FIELD_W-1:0] canvas_h_cfg;
   logic                   letterbox_cfg;

   tile_req_type  tile_requests[$];       // requests not yet offered
   placement_type pending_placements[$];  // predicted placements awaiting their transfer

   int tiles_queued;         // requests handed to the driver so far
   int tiles_offered;        // requests put on the channel
   int tiles_accepted;       // request transfers seen
   int placements_checked;   // response transfers seen
   int placements_seen;      // response transfers the receiver has reacted to
   int req_gap_left;
   int rsp_stall_left;
   int rsp_hold_off;
   int failures;
   bit steady_flow;          // no idling on either side while set

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Placement predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned clamp_dim(longint unsigned v);
      if (v < 2) return 2;
      if (v > MAX_DIMENSION_DEFAULT) return MAX_DIMENSION_DEFAULT;
      return v;
   endfunction

   function automatic placement_type place_tile(tile_req_type t);
      longint unsigned tiles, w, h, sw, sh, cols, rows, cell_w, cell_h;
      longint unsigned fw, fh, off_x, off_y, dx, dy;
      longint unsigned c, r, aspect, diff, score, best_score;
      bit wide;
      placement_type p;
      tiles = t.tile_count;
      if (tiles > MAX_TILES_DEFAULT) tiles = MAX_TILES_DEFAULT;
      sw = clamp_dim(t.source_width);
      sh = clamp_dim(t.source_height);
      w = clamp_dim(canvas_w_cfg);
      h = clamp_dim(canvas_h_cfg);
      wide = (2 * w >= 3 * h);

      // Fixed layouts up to four tiles, column search above that
      if (tiles <= 1) begin
         cols = 1;
         rows = 1;
      end else if (tiles == 2) begin
         cols = wide ? 2 : 1;
         rows = wide ? 1 : 2;
      end else if (tiles == 3) begin
         cols = wide ? 3 : 2;
         rows = wide ? 1 : 2;
      end else if (tiles == 4) begin
         cols = 2;
         rows = 2;
      end else begin
         best_score = '1;
         cols = 1;
         rows = tiles;
         for (c = 1; c <= tiles; c++) begin
            r = (tiles + c - 1) / c;
            aspect = (w * r * 65536) / (h * c);
            diff = (aspect >= ASPECT_TARGET_Q16) ? aspect - ASPECT_TARGET_Q16
                                                 : ASPECT_TARGET_Q16 - aspect;
            score = diff + EMPTY_PENALTY_Q16 * (c * r - tiles);
            // strict compare: the first minimum wins
            if (score < best_score) begin
               best_score = score;
               cols = c;
               rows = r;
            end
         end
      end

      cell_w = w / cols;
      cell_h = h / rows;
      off_x = 0;
      off_y = 0;
      if (letterbox_cfg) begin
         if (sw * cell_h > cell_w * sh) begin
            fw = cell_w;
            fh = (cell_w * sh) / sw;
            off_y = (cell_h - fh) / 2;
            off_y[0] = 1'b0;
         end else begin
            fw = (cell_h * sw) / sh;
            fh = cell_h;
            off_x = (cell_w - fw) / 2;
            off_x[0] = 1'b0;
         end
         fw[0] = 1'b0;
         fh[0] = 1'b0;
      end else begin
         fw = cell_w;
         fh = cell_h;
      end

      dx = (t.tile_index % cols) * cell_w + off_x;
      dy = (t.tile_index / cols) * cell_h + off_y;

      p.grid_columns = cols[GRID_W-1:0];
      p.grid_rows    = rows[GRID_W-1:0];
      p.dest_x       = (dx > FIELD13_MAX) ? FIELD13_MAX : dx[DIM_FIELD_W-1:0];
      p.dest_y       = (dy > FIELD13_MAX) ? FIELD13_MAX : dy[DIM_FIELD_W-1:0];
      p.fit_width    = fw[DIM_FIELD_W-1:0];
      p.fit_height   = fh[DIM_FIELD_W-1:0];
      // flags use the unsaturated corner
      p.luma_fits    = (dx + fw <= w) && (dy + fh <= h);
      p.chroma_fits  = (dx / 2 + fw / 2 <= w / 2) && (dy / 2 + fh / 2 <= h / 2);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: change inputs at the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      tile_req_type next_req;
      if (!reset) begin
         if (req_ch.valid && tiles_offered != tiles_accepted) begin
            // hold the offer until its transfer
         end else if (req_gap_left > 0) begin
            req_gap_left <= req_gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (tile_requests.size() > 0) begin
            // back-to-back items keep valid high with a single assignment
            next_req = tile_requests.pop_front();
            req_ch.tile_count    <= next_req.tile_count;
            req_ch.tile_index    <= next_req.tile_index;
            req_ch.source_width  <= next_req.source_width;
            req_ch.source_height <= next_req.source_height;
            req_ch.valid         <= 1'b1;
            tiles_offered        <= tiles_offered + 1;
            req_gap_left         <= steady_flow ? 0 : $urandom_range(0, 5);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: random stall after each transfer, plus a long hold-off
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : rsp_receiver
      int stall;
      if (!reset) begin
         if (rsp_hold_off > 0) begin
            rsp_hold_off <= rsp_hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ch.ready   <= 1'b0;
         end else if (placements_seen != placements_checked) begin
            placements_seen <= placements_checked;
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            rsp_stall_left <= (stall > 0) ? stall - 1 : 0;
            rsp_ch.ready   <= (stall == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each request transfer, check each response transfer
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : transfer_monitor
      tile_req_type  seen_req;
      placement_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_req.tile_count    = req_ch.tile_count;
            seen_req.tile_index    = req_ch.tile_index;
            seen_req.source_width  = req_ch.source_width;
            seen_req.source_height = req_ch.source_height;
            pending_placements = {pending_placements, place_tile(seen_req)};
            tiles_accepted <= tiles_accepted + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            placements_checked <= placements_checked + 1;
            if (pending_placements.size() == 0) begin
               $error("placement transfer with no request outstanding");
               failures++;
            end else begin
               want = pending_placements.pop_front();
               check_field("grid_columns", want.grid_columns, rsp_ch.grid_columns);
               check_field("grid_rows", want.grid_rows, rsp_ch.grid_rows);
               check_field("dest_x", want.dest_x, rsp_ch.dest_x);
               check_field("dest_y", want.dest_y, rsp_ch.dest_y);
               check_field("fit_width", want.fit_width, rsp_ch.fit_width);
               check_field("fit_height", want.fit_height, rsp_ch.fit_height);
               check_field("luma_fits", want.luma_fits, rsp_ch.luma_fits);
               check_field("chroma_fits", want.chroma_fits, rsp_ch.chroma_fits);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_write(csr_reg_type reg_index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write all three registers; junk in the upper data bits must be ignored
   task automatic set_canvas(int unsigned width, int unsigned height, bit letterbox);
      csr_write(REG_CANVAS_WIDTH, {19'($urandom), 13'(width)});
      csr_write(REG_CANVAS_HEIGHT, {19'($urandom), 13'(height)});
      csr_write(REG_KEEP_ASPECT, {31'($urandom), letterbox});
      canvas_w_cfg  = 13'(width);
      canvas_h_cfg  = 13'(height);
      letterbox_cfg = letterbox;
   endtask

   task automatic queue_tile(int unsigned count, int unsigned index,
                             int unsigned sw, int unsigned sh);
      tile_req_type t;
      t.tile_count    = COUNT_W'(count);
      t.tile_index    = INDEX_W'(index);
      t.source_width  = DIM_FIELD_W'(sw);
      t.source_height = DIM_FIELD_W'(sh);
      tile_requests = {tile_requests, t};
      tiles_queued++;
   endtask

   function automatic int unsigned random_dim();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 8191);   // whole field, clamps included
         1:       return $urandom_range(0, 16);
         default: return $urandom_range(2, 4096);
      endcase
   endfunction

   function automatic int unsigned random_canvas_dim();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 8191);
      return $urandom_range(2, 4096);
   endfunction

   // Half the items use four tiles or fewer; the other half take the long column search
   task automatic queue_random_tile();
      int unsigned count;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: count = $urandom_range(0, 4);
         9:             count = $urandom_range(17, 31);
         default:       count = $urandom_range(5, 16);
      endcase
      queue_tile(count, $urandom_range(0, 15), random_dim(), random_dim());
   endtask

   // Pause the sender until every predicted placement has been checked
   task automatic wait_drained();
      do @(negedge clock);
      while (tiles_accepted != tiles_queued || pending_placements.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.tile_count  = '0;
      req_ch.tile_index  = '0;
      req_ch.source_width  = '0;
      req_ch.source_height = '0;
      rsp_ch.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      canvas_w_cfg       = CANVAS_WIDTH_RESET;
      canvas_h_cfg       = CANVAS_HEIGHT_RESET;
      letterbox_cfg      = KEEP_ASPECT_RESET;
      tiles_queued       = 0;
      tiles_offered      = 0;
      tiles_accepted     = 0;
      placements_checked = 0;
      placements_seen    = 0;
      req_gap_left       = 0;
      rsp_stall_left     = 0;
      rsp_hold_off       = 0;
      failures           = 0;
      steady_flow        = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items on the reset canvas (1280x720, letterbox, wide)
      queue_tile(0, 0, 1920, 1080);      // zero tiles: 1x1 grid
      queue_tile(1, 0, 1280, 720);
      queue_tile(2, 1, 1080, 1920);      // tall source, pillarbox
      queue_tile(3, 2, 640, 480);
      queue_tile(4, 3, 4096, 4096);
      queue_tile(5, 4, 1920, 1080);      // smallest searched count
      queue_tile(16, 15, 2, 2);
      queue_tile(16, 0, 4096, 2);
      queue_tile(17, 9, 2, 4096);        // count above the tile limit
      queue_tile(31, 15, 8191, 8191);    // largest count and oversize source
      queue_tile(9, 7, 0, 1);            // undersize source
      queue_tile(1, 15, 1920, 1080);     // index past the count, corner off canvas
      queue_tile(2, 15, 1920, 1080);
      queue_tile(3, 5, 720, 1280);
      queue_tile(6, 5, 1280, 720);
      queue_tile(7, 3, 1000, 1000);
      queue_tile(12, 11, 352, 288);
      queue_tile(8, 15, 4095, 4097);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady_flow = (phase == 0 || phase == 10);
         case (phase)
            0:       set_canvas(1920, 1080, 1'b0);
            1:       set_canvas(2, 2, 1'b1);        // tiny canvas: empty cells
            2:       set_canvas(4096, 4096, 1'b0);
            3:       set_canvas(8191, 0, 1'b1);     // both dims clamp
            4:       set_canvas(1, 8191, 1'b0);
            5:       set_canvas(720, 1280, 1'b1);   // tall canvas
            6:       set_canvas(1281, 854, 1'b1);   // exactly on the wide boundary
            7:       set_canvas(1280, 854, 1'b1);   // just short of wide
            default: set_canvas(random_canvas_dim(), random_canvas_dim(),
                                1'($urandom_range(0, 1)));
         endcase
         if (phase == 1) begin
            queue_tile(16, 15, 1920, 1080);
            queue_tile(5, 0, 2, 2);
            queue_tile(3, 2, 4096, 2);
         end
         // Stall the receiver long enough to back the block up into its input
         if (phase == 8) rsp_hold_off = LONG_HOLD_CYCLES;
         for (int i = 0; i < TILES_PER_PHASE; i++) queue_random_tile();
         wait_drained();
      end

      // Advance past the longest sequence to catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/gtp_pkg.sv
design/gtp_channels.sv
design/gtp_div.sv
design/grid_tile_placement.sv
test/tb.sv
